// File: src/euler_zyx_to_rotation_matrix_unit_assert.svh
// Assertion macros for the Euler ZYX rotation matrix unit.
`ifndef EULER_ZYX_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH
`define EULER_ZYX_TO_ROTATION_MATRIX_UNIT_ASSERT_SVH

// Check prop on every clock edge outside reset.
`define EZR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Check prop on every clock edge, reset included.
`define EZR_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/ezr_pkg.sv
`timescale 1ns / 1ps
package ezr_pkg;
	localparam int CORDIC_STAGES = 16;
	localparam int ENTRY_WIDTH = 16;
	localparam int ANGLE_WIDTH = 16;
	localparam int FRAC = 31;
	localparam int XW = 34;
	localparam int ZW = 28;
	localparam int SW = XW + 1;
	localparam int PW = 2 * XW;
	localparam int SH = 32 - ENTRY_WIDTH;
	localparam int LANE_LAT = CORDIC_STAGES + 2;
	localparam int MAT_LAT = 3;
	localparam int LAT = LANE_LAT + MAT_LAT;

	localparam logic signed [17:0] HALF_TURN = 18'sd23040;
	localparam logic signed [17:0] QUARTER_TURN = 18'sd11520;
	localparam logic signed [17:0] FULL_TURN = 18'sd46080;
	localparam logic signed [XW-1:0] GAIN = XW'(64'sd1304065748);
	localparam logic signed [PW-1:0] MUL_RND = PW'(64'sd1) <<< (FRAC - 1);
	localparam logic signed [SW-1:0] OUT_RND = SW'((64'sd1 <<< SH) >>> 1);
	localparam logic signed [SW-1:0] ENTRY_HI = SW'((64'sd1 <<< (ENTRY_WIDTH - 1)) - 1);
	localparam logic signed [SW-1:0] ENTRY_LO = -ENTRY_HI - SW'(1);

	typedef logic signed [ANGLE_WIDTH-1:0] angle_t;
	typedef logic signed [XW-1:0] sc_t;
	typedef logic signed [ZW-1:0] resid_t;
	typedef logic signed [SW-1:0] sum_t;
	typedef logic signed [ENTRY_WIDTH-1:0] entry_t;

	typedef struct packed {
		sc_t s;
		sc_t c;
	} sc_pair_t;

	function automatic resid_t atan_q16(input int i);
		logic [22:0] v;
		case (i)
			0: v = 23'd2949120;
			1: v = 23'd1740967;
			2: v = 23'd919879;
			3: v = 23'd466945;
			4: v = 23'd234379;
			5: v = 23'd117304;
			6: v = 23'd58666;
			7: v = 23'd29335;
			8: v = 23'd14668;
			9: v = 23'd7334;
			10: v = 23'd3667;
			11: v = 23'd1833;
			12: v = 23'd917;
			13: v = 23'd458;
			14: v = 23'd229;
			15: v = 23'd115;
			16: v = 23'd57;
			17: v = 23'd29;
			18: v = 23'd14;
			19: v = 23'd7;
			20: v = 23'd4;
			21: v = 23'd2;
			22: v = 23'd1;
			default: v = 23'd0;
		endcase
		return resid_t'(v);
	endfunction

	function automatic sc_t mulq(input sc_t a, input sc_t b);
		logic signed [PW-1:0] p;
		p = PW'(a) * PW'(b);
		p = (p + MUL_RND) >>> FRAC;
		return p[XW-1:0];
	endfunction

	function automatic entry_t to_entry(input sum_t v);
		sum_t t;
		t = (v + OUT_RND) >>> SH;
		if (t > ENTRY_HI)
			t = ENTRY_HI;
		if (t < ENTRY_LO)
			t = ENTRY_LO;
		return t[ENTRY_WIDTH-1:0];
	endfunction
endpackage

// File: src/ezr_cordic_lane.sv
`timescale 1ns / 1ps
module ezr_cordic_lane (
	input  logic              clk,
	input  logic              en,
	input  ezr_pkg::angle_t   angle,
	output ezr_pkg::sc_pair_t sc
);
	localparam int N = ezr_pkg::CORDIC_STAGES;

	logic signed [17:0] a_w;
	logic signed [17:0] a_f;
	logic               neg_f;

	ezr_pkg::sc_t    x_sk [0:N];
	ezr_pkg::sc_t    y_sk [0:N];
	ezr_pkg::resid_t z_sk [0:N];
	logic            n_sk [0:N];
	ezr_pkg::sc_pair_t sc_q;

	always_comb begin
		a_w = 18'(angle);
		if (a_w > ezr_pkg::HALF_TURN)
			a_w = a_w - ezr_pkg::FULL_TURN;
		if (a_w < -ezr_pkg::HALF_TURN)
			a_w = a_w + ezr_pkg::FULL_TURN;
		a_f = a_w;
		neg_f = 1'b0;
		if (a_w > ezr_pkg::QUARTER_TURN) begin
			a_f = a_w - ezr_pkg::HALF_TURN;
			neg_f = 1'b1;
		end else if (a_w < -ezr_pkg::QUARTER_TURN) begin
			a_f = a_w + ezr_pkg::HALF_TURN;
			neg_f = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_sk[0] <= ezr_pkg::GAIN;
			y_sk[0] <= '0;
			z_sk[0] <= ezr_pkg::resid_t'(a_f) <<< 9;
			n_sk[0] <= neg_f;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		always_ff @(posedge clk) begin
			if (en) begin
				n_sk[i+1] <= n_sk[i];
				if (z_sk[i] >= 0) begin
					x_sk[i+1] <= x_sk[i] - (y_sk[i] >>> i);
					y_sk[i+1] <= y_sk[i] + (x_sk[i] >>> i);
					z_sk[i+1] <= z_sk[i] - ezr_pkg::atan_q16(i);
				end else begin
					x_sk[i+1] <= x_sk[i] + (y_sk[i] >>> i);
					y_sk[i+1] <= y_sk[i] - (x_sk[i] >>> i);
					z_sk[i+1] <= z_sk[i] + ezr_pkg::atan_q16(i);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sc_q.s <= n_sk[N] ? -y_sk[N] : y_sk[N];
			sc_q.c <= n_sk[N] ? -x_sk[N] : x_sk[N];
		end
	end

	assign sc = sc_q;
endmodule

// File: src/ezr_matrix.sv
`timescale 1ns / 1ps
module ezr_matrix (
	input  logic              clk,
	input  logic              en,
	input  ezr_pkg::sc_pair_t rx,
	input  ezr_pkg::sc_pair_t ry,
	input  ezr_pkg::sc_pair_t rz,
	output ezr_pkg::entry_t   m [9]
);
	ezr_pkg::sc_t czsy_s1, szsy_s1, czcy_s1, szcy_s1, szcx_s1, szsx_s1;
	ezr_pkg::sc_t czcx_s1, czsx_s1, cysx_s1, cycx_s1, nsy_s1, sx_s1, cx_s1;
	ezr_pkg::sc_t p01_s2, p02_s2, p11_s2, p12_s2;
	ezr_pkg::sc_t czcy_s2, szcy_s2, szcx_s2, szsx_s2, czcx_s2, czsx_s2;
	ezr_pkg::sc_t cysx_s2, cycx_s2, nsy_s2;
	ezr_pkg::entry_t m_s3 [9];

	always_ff @(posedge clk) begin
		if (en) begin
			czsy_s1 <= ezr_pkg::mulq(rz.c, ry.s);
			szsy_s1 <= ezr_pkg::mulq(rz.s, ry.s);
			czcy_s1 <= ezr_pkg::mulq(rz.c, ry.c);
			szcy_s1 <= ezr_pkg::mulq(rz.s, ry.c);
			szcx_s1 <= ezr_pkg::mulq(rz.s, rx.c);
			szsx_s1 <= ezr_pkg::mulq(rz.s, rx.s);
			czcx_s1 <= ezr_pkg::mulq(rz.c, rx.c);
			czsx_s1 <= ezr_pkg::mulq(rz.c, rx.s);
			cysx_s1 <= ezr_pkg::mulq(ry.c, rx.s);
			cycx_s1 <= ezr_pkg::mulq(ry.c, rx.c);
			nsy_s1  <= -ry.s;
			sx_s1   <= rx.s;
			cx_s1   <= rx.c;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			p01_s2  <= ezr_pkg::mulq(czsy_s1, sx_s1);
			p02_s2  <= ezr_pkg::mulq(czsy_s1, cx_s1);
			p11_s2  <= ezr_pkg::mulq(szsy_s1, sx_s1);
			p12_s2  <= ezr_pkg::mulq(szsy_s1, cx_s1);
			czcy_s2 <= czcy_s1;
			szcy_s2 <= szcy_s1;
			szcx_s2 <= szcx_s1;
			szsx_s2 <= szsx_s1;
			czcx_s2 <= czcx_s1;
			czsx_s2 <= czsx_s1;
			cysx_s2 <= cysx_s1;
			cycx_s2 <= cycx_s1;
			nsy_s2  <= nsy_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s3[0] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(czcy_s2));
			m_s3[1] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(p01_s2) - ezr_pkg::sum_t'(szcx_s2));
			m_s3[2] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(p02_s2) + ezr_pkg::sum_t'(szsx_s2));
			m_s3[3] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(szcy_s2));
			m_s3[4] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(p11_s2) + ezr_pkg::sum_t'(czcx_s2));
			m_s3[5] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(p12_s2) - ezr_pkg::sum_t'(czsx_s2));
			m_s3[6] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(nsy_s2));
			m_s3[7] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(cysx_s2));
			m_s3[8] <= ezr_pkg::to_entry(ezr_pkg::sum_t'(cycx_s2));
		end
	end

	assign m = m_s3;
endmodule

// File: src/euler_zyx_to_rotation_matrix_unit.sv
`timescale 1ns / 1ps
// Euler ZYX angles to rotation matrix R = Rz * Ry * Rx.
// Input channel: in_valid / in_stall carry roll_deg, pitch_deg, yaw_deg,
//   signed degrees times 128; angles outside plus or minus 180 wrap once.
// Output channel: out_valid / out_stall carry m00..m22, signed Q1.15,
//   with +1 saturated to 32767.
// A beat is taken when valid is high and stall is low on its channel.
// Pipeline: one fold stage, one register per CORDIC stage, one sign stage,
//   then three product stages. Throughput: one beat per cycle unless held.
// Three CORDIC lanes run side by side, one per angle, and the product stages
//   merge their sine and cosine.
// The whole pipeline advances together; it holds only while a result sits
//   at the output and out_stall is high, and in_stall is raised then.
//   Bubbles ahead of a held result do not close up.
// Reset clears the valid bits only; the pipeline comes up empty.
module euler_zyx_to_rotation_matrix_unit (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	input  ezr_pkg::angle_t roll_deg,
	input  ezr_pkg::angle_t pitch_deg,
	input  ezr_pkg::angle_t yaw_deg,
	output logic            out_valid,
	input  logic            out_stall,
	output ezr_pkg::entry_t m00,
	output ezr_pkg::entry_t m01,
	output ezr_pkg::entry_t m02,
	output ezr_pkg::entry_t m10,
	output ezr_pkg::entry_t m11,
	output ezr_pkg::entry_t m12,
	output ezr_pkg::entry_t m20,
	output ezr_pkg::entry_t m21,
	output ezr_pkg::entry_t m22
);
	logic                    en;
	logic [ezr_pkg::LAT-1:0] vld_q;
	ezr_pkg::sc_pair_t       rx, ry, rz;
	ezr_pkg::entry_t         m [9];

	assign en = !(vld_q[ezr_pkg::LAT-1] && out_stall);
	assign in_stall = !en;
	assign out_valid = vld_q[ezr_pkg::LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[ezr_pkg::LAT-2:0], in_valid};
		end
	end

	ezr_cordic_lane u_lane_x (.clk(clk), .en(en), .angle(roll_deg), .sc(rx));
	ezr_cordic_lane u_lane_y (.clk(clk), .en(en), .angle(pitch_deg), .sc(ry));
	ezr_cordic_lane u_lane_z (.clk(clk), .en(en), .angle(yaw_deg), .sc(rz));

	ezr_matrix u_matrix (
		.clk(clk), .en(en), .rx(rx), .ry(ry), .rz(rz), .m(m)
	);

	assign m00 = m[0];
	assign m01 = m[1];
	assign m02 = m[2];
	assign m10 = m[3];
	assign m11 = m[4];
	assign m12 = m[5];
	assign m20 = m[6];
	assign m21 = m[7];
	assign m22 = m[8];
endmodule

// File: src/ezr_checker.sv
`timescale 1ns / 1ps
`include "euler_zyx_to_rotation_matrix_unit_assert.svh"
module ezr_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_stall,
	input ezr_pkg::angle_t roll_deg,
	input ezr_pkg::angle_t pitch_deg,
	input ezr_pkg::angle_t yaw_deg,
	input logic            out_valid,
	input logic            out_stall,
	input ezr_pkg::entry_t m00,
	input ezr_pkg::entry_t m01,
	input ezr_pkg::entry_t m02,
	input ezr_pkg::entry_t m10,
	input ezr_pkg::entry_t m11,
	input ezr_pkg::entry_t m12,
	input ezr_pkg::entry_t m20,
	input ezr_pkg::entry_t m21,
	input ezr_pkg::entry_t m22
);
	logic [9*ezr_pkg::ENTRY_WIDTH-1:0] mat;

	assign mat = {m00, m01, m02, m10, m11, m12, m20, m21, m22};

	`EZR_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid, "output beat dropped while stalled")
	`EZR_ASSERT(a_out_stable, out_valid && out_stall |=> $stable(mat), "stalled output beat changed")
	`EZR_ASSERT(a_in_stall, in_stall == (out_valid && out_stall), "input stall not tied to held output")
	`EZR_ASSERT(a_rise_moved, $rose(out_valid) |-> $past(!in_stall), "output appeared while pipeline held")
endmodule

bind euler_zyx_to_rotation_matrix_unit ezr_checker u_ezr_checker (.*);

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
	typedef logic [8:0][ezr_pkg::ENTRY_WIDTH-1:0] matrix_t;

	localparam longint ATAN_DEG_Q16 [24] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115,
		57, 29, 14, 7, 4, 2, 1, 0
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	ezr_pkg::angle_t roll_deg = '0;
	ezr_pkg::angle_t pitch_deg = '0;
	ezr_pkg::angle_t yaw_deg = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	ezr_pkg::entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;

	matrix_t pending_matrices [$];
	int mismatches = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;

	euler_zyx_to_rotation_matrix_unit u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.roll_deg(roll_deg), .pitch_deg(pitch_deg), .yaw_deg(yaw_deg),
		.out_valid(out_valid), .out_stall(out_stall),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic void angle_sincos(input ezr_pkg::angle_t ang, output longint s,
		output longint c);
		longint a, x, y, z, xs, ys;
		bit flip;
		a = ang;
		flip = 1'b0;
		x = 1304065748;
		y = 0;
		if (a > 23040)
			a -= 46080;
		if (a < -23040)
			a += 46080;
		if (a > 11520) begin
			a -= 23040;
			flip = 1'b1;
		end else if (a < -11520) begin
			a += 23040;
			flip = 1'b1;
		end
		z = a * 512;
		for (int i = 0; i < ezr_pkg::CORDIC_STAGES && i < 24; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x -= ys;
				y += xs;
				z -= ATAN_DEG_Q16[i];
			end else begin
				x += ys;
				y -= xs;
				z += ATAN_DEG_Q16[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint q31_product(input longint a, input longint b);
		return (a * b + (longint'(1) <<< 30)) >>> 31;
	endfunction

	function automatic logic [ezr_pkg::ENTRY_WIDTH-1:0] q31_to_entry(input longint v);
		longint hi, lo;
		hi = (longint'(1) <<< (ezr_pkg::ENTRY_WIDTH - 1)) - 1;
		lo = -hi - 1;
		if (ezr_pkg::ENTRY_WIDTH < 32)
			v = (v + (longint'(1) <<< (31 - ezr_pkg::ENTRY_WIDTH)))
				>>> (32 - ezr_pkg::ENTRY_WIDTH);
		if (v > hi)
			v = hi;
		if (v < lo)
			v = lo;
		return v[ezr_pkg::ENTRY_WIDTH-1:0];
	endfunction

	function automatic matrix_t rotation_of(input ezr_pkg::angle_t r, input ezr_pkg::angle_t p,
		input ezr_pkg::angle_t w);
		longint sx, cx, sy, cy, sz, cz, czsy, szsy;
		matrix_t m;
		angle_sincos(r, sx, cx);
		angle_sincos(p, sy, cy);
		angle_sincos(w, sz, cz);
		czsy = q31_product(cz, sy);
		szsy = q31_product(sz, sy);
		m[0] = q31_to_entry(q31_product(cz, cy));
		m[1] = q31_to_entry(q31_product(czsy, sx) - q31_product(sz, cx));
		m[2] = q31_to_entry(q31_product(czsy, cx) + q31_product(sz, sx));
		m[3] = q31_to_entry(q31_product(sz, cy));
		m[4] = q31_to_entry(q31_product(szsy, sx) + q31_product(cz, cx));
		m[5] = q31_to_entry(q31_product(szsy, cx) - q31_product(cz, sx));
		m[6] = q31_to_entry(-sy);
		m[7] = q31_to_entry(q31_product(cy, sx));
		m[8] = q31_to_entry(q31_product(cy, cx));
		return m;
	endfunction

	always @(posedge clk)
		out_stall <= ($urandom_range(99) < recv_stall_pct);

	always @(negedge clk) begin
		matrix_t got, want;
		if (arst_n && out_valid && !out_stall) begin
			got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
			if (pending_matrices.size() == 0) begin
				$display("%0t: unexpected matrix beat %h", $time, got);
				mismatches++;
			end else begin
				want = pending_matrices.pop_front();
				for (int k = 0; k < 9; k++)
					if (got[k] !== want[k]) begin
						$display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
							$signed(want[k]), $signed(got[k]));
						mismatches++;
					end
			end
		end
	end

	task automatic send_pose(input ezr_pkg::angle_t r, input ezr_pkg::angle_t p,
		input ezr_pkg::angle_t w);
		bit taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		roll_deg <= r;
		pitch_deg <= p;
		yaw_deg <= w;
		do begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end while (!taken);
		pending_matrices.push_back(rotation_of(r, p, w));
	endtask

	function automatic ezr_pkg::angle_t any_angle();
		if ($urandom_range(9) == 0)
			return ezr_pkg::angle_t'($urandom);
		return ezr_pkg::angle_t'(int'($urandom_range(46080)) - 23040);
	endfunction

	task automatic test_directed();
		ezr_pkg::angle_t edges [14] = '{16'sd0, 16'sd1, -16'sd1, 16'sd11520, -16'sd11520,
			16'sd11521, -16'sd11521, 16'sd23040, -16'sd23040, 16'sd23041, -16'sd23041,
			16'sd32767, -16'sd32768, 16'sd5760};
		foreach (edges[i])
			send_pose(edges[i], edges[(i + 5) % 14], edges[(i + 9) % 14]);
		send_pose(16'sd23040, 16'sd23040, 16'sd23040);
		send_pose(-16'sd23040, 16'sd11520, -16'sd11520);
		send_pose(16'sd0, 16'sd11520, 16'sd0);
		send_pose(16'sd0, -16'sd11520, 16'sd23040);
		send_pose(16'sd11520, 16'sd0, 16'sd11520);
	endtask

	task automatic test_random(input int n, input int idle_pct, input int stall_pct);
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		repeat (n)
			send_pose(any_angle(), any_angle(), any_angle());
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		send_idle_pct = 0;
		while (pending_matrices.size() != 0)
			@(posedge clk);
		recv_stall_pct = 0;
		repeat (ezr_pkg::LAT + 10) @(posedge clk);
	endtask

	initial begin
		#4_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(440, 0, 0);
		test_random(440, 73, 0);
		test_random(440, 0, 73);
		test_random(440, 28, 28);
		drain();
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule
